>>> rtl/s7seg_pkg.sv
package s7seg_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned RADIX_W  = 8;
	localparam int unsigned SEG_W    = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned DIV_W    = 5;  // divisor width, bases up to 16
	localparam int unsigned REM_W    = 4;  // remainder always below 16
	localparam int unsigned OUT_DIGITS = 4;

	localparam logic [SEG_W-1:0] SEG_BLANK  = 8'h00;
	localparam logic [SEG_W-1:0] SEG_OVER   = 8'h01;
	localparam logic [SEG_W-1:0] SEG_UNDER  = 8'h08;
	localparam logic [SEG_W-1:0] SEG_HYPHEN = 8'h40;
	localparam logic [SEG_W-1:0] SEG_DOT    = 8'h80;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd16;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_SHOWN    = 2'd0,
		STATUS_BAD_BASE = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic                start;
		logic [VALUE_W-1:0]  dividend;
		logic [DIV_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [VALUE_W-1:0]  quotient;
		logic [REM_W-1:0]    remainder;
	} div_rsp_t;

	// Hex glyph table: 0-9, A, b, C, d, E, F.
	function automatic logic [SEG_W-1:0] glyph(input logic [REM_W-1:0] d);
		logic [SEG_W-1:0] g;
		case (d)
			4'h0: g = 8'h3F;
			4'h1: g = 8'h06;
			4'h2: g = 8'h5B;
			4'h3: g = 8'h4F;
			4'h4: g = 8'h66;
			4'h5: g = 8'h6D;
			4'h6: g = 8'h7D;
			4'h7: g = 8'h07;
			4'h8: g = 8'h7F;
			4'h9: g = 8'h6F;
			4'hA: g = 8'h77;
			4'hB: g = 8'h7C;
			4'hC: g = 8'h39;
			4'hD: g = 8'h5E;
			4'hE: g = 8'h79;
			default: g = 8'h71;
		endcase
		return g;
	endfunction

endpackage

>>> rtl/s7seg_if.sv
interface s7seg_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [s7seg_pkg::VALUE_W-1:0] value_in;
	logic [s7seg_pkg::RADIX_W-1:0]    radix;
	logic                             pad_zeros;

	modport source (output valid, output value_in, output radix, output pad_zeros,
		input ready);
	modport sink (input valid, input value_in, input radix, input pad_zeros,
		output ready);
endinterface

interface s7seg_out_if;
	logic                             valid;
	logic                             ready;
	logic [s7seg_pkg::SEG_W-1:0]      digit0_segments;
	logic [s7seg_pkg::SEG_W-1:0]      digit1_segments;
	logic [s7seg_pkg::SEG_W-1:0]      digit2_segments;
	logic [s7seg_pkg::SEG_W-1:0]      digit3_segments;
	logic [s7seg_pkg::STATUS_W-1:0]   status;

	modport source (output valid, output digit0_segments, output digit1_segments,
		output digit2_segments, output digit3_segments, output status, input ready);
	modport sink (input valid, input digit0_segments, input digit1_segments,
		input digit2_segments, input digit3_segments, input status, output ready);
endinterface

>>> rtl/s7seg_div.sv
// Restoring divider, one quotient bit per cycle.
module s7seg_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  s7seg_pkg::div_req_t    req,
	output s7seg_pkg::div_rsp_t    rsp
);

	localparam int unsigned CNT_W = $clog2(s7seg_pkg::VALUE_W);

	logic [s7seg_pkg::REM_W-1:0]   rem_q;
	logic [s7seg_pkg::VALUE_W-1:0] quo_q;
	logic [s7seg_pkg::DIV_W-1:0]   div_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [s7seg_pkg::DIV_W-1:0]   trial;
	logic [s7seg_pkg::DIV_W-1:0]   diff;
	logic                          ge;

	always_comb begin
		trial = {rem_q, quo_q[s7seg_pkg::VALUE_W-1]};
		ge    = (trial >= div_q);
		diff  = trial - div_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(s7seg_pkg::VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= ge ? diff[s7seg_pkg::REM_W-1:0] : trial[s7seg_pkg::REM_W-1:0];
			quo_q <= {quo_q[s7seg_pkg::VALUE_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> rtl/signed_number_to_seven_segment.sv
// Sequence: each drawn digit passes START, the divider's bit-serial steps and WAIT, which
//   collects the digit; FINISH then loads the output register. An invalid base goes
//   straight from IDLE to FINISH. The shared bit-serial divider sets the pace.
// Throughput: one item at a time; the next item is taken once the row sits in the output
//   register, even while that result still waits for the sink.
// Reset: arst_n clears the sequencer, the divider control and the output valid.
module signed_number_to_seven_segment #(
	parameter int unsigned DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	s7seg_in_if.sink    item,
	s7seg_out_if.source result
);

	localparam int unsigned PW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int unsigned ROWN = (DIGITS > s7seg_pkg::OUT_DIGITS) ? DIGITS
		: s7seg_pkg::OUT_DIGITS;

	// Sequencer: IDLE takes an item, START kicks the divider for one digit,
	// WAIT collects quotient and remainder, FINISH builds and hands off the row.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_START  = 4'b0010,
		ST_WAIT   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	logic [s7seg_pkg::VALUE_W-1:0] mag_q;
	logic [s7seg_pkg::DIV_W-1:0]   base_q;
	logic                          neg_q;
	logic                          pad_q;
	logic                          bad_q;
	logic                          lead_free_q;
	logic [PW-1:0]                 pos_q;
	logic [s7seg_pkg::SEG_W-1:0]   row_q [DIGITS];

	logic [s7seg_pkg::SEG_W-1:0]   out_seg_q [s7seg_pkg::OUT_DIGITS];
	logic [s7seg_pkg::STATUS_W-1:0] out_status_q;
	logic                          out_valid_q;

	s7seg_pkg::div_req_t div_req;
	s7seg_pkg::div_rsp_t div_rsp;

	logic                          in_xfer;
	logic                          out_free;
	logic                          raw_neg;
	logic                          radix_ok;
	logic [s7seg_pkg::VALUE_W-1:0] raw_u;
	logic [s7seg_pkg::VALUE_W-1:0] raw_mag;
	logic                          more;
	logic                          overflow;
	logic [s7seg_pkg::SEG_W-1:0]   fin_row [ROWN];
	s7seg_pkg::status_t            fin_status;

	assign item.ready = (state_q == ST_IDLE);
	assign in_xfer    = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	always_comb begin
		raw_u    = item.value_in;
		raw_neg  = raw_u[s7seg_pkg::VALUE_W-1];
		// two's complement negate; the most negative value stays as its magnitude
		raw_mag  = raw_neg ? (~raw_u + 1'b1) : raw_u;
		radix_ok = (item.radix >= s7seg_pkg::RADIX_MIN) &&
			(item.radix <= s7seg_pkg::RADIX_MAX);
	end

	assign div_req.start    = (state_q == ST_START);
	assign div_req.dividend = mag_q;
	assign div_req.divisor  = base_q;

	s7seg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Keep drawing while the quotient is nonzero or padding asks for more,
	// and a position remains to the left.
	assign more = ((div_rsp.quotient != '0) || pad_q) && (pos_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= radix_ok ? ST_START : ST_FINISH;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						state_q <= more ? ST_START : ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the item in flight.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mag_q       <= raw_mag;
			base_q      <= item.radix[s7seg_pkg::DIV_W-1:0];
			neg_q       <= raw_neg;
			pad_q       <= item.pad_zeros;
			bad_q       <= !radix_ok;
			lead_free_q <= 1'b0;
			pos_q       <= PW'(DIGITS - 1);
			for (int k = 0; k < DIGITS; k++) begin
				row_q[k] <= s7seg_pkg::SEG_BLANK;
			end
		end else if (state_q == ST_START) begin
			// leftmost digit drawn from a zero quotient counts as free
			if ((pos_q == '0) && (mag_q == '0)) begin
				lead_free_q <= 1'b1;
			end
		end else if ((state_q == ST_WAIT) && div_rsp.done) begin
			row_q[pos_q] <= s7seg_pkg::glyph(div_rsp.remainder);
			mag_q        <= div_rsp.quotient;
			if (more) begin
				pos_q <= pos_q - 1'b1;
			end else if (pos_q != '0) begin
				// stopped with positions left undrawn on the left
				lead_free_q <= 1'b1;
			end
		end
	end

	// Final row: blank for a bad base, over/underlines on overflow, else the digits with a sign mark if negative.
	always_comb begin
		overflow = !bad_q && (mag_q != '0);
		if (bad_q) begin
			fin_status = s7seg_pkg::STATUS_BAD_BASE;
		end else if (overflow) begin
			fin_status = s7seg_pkg::STATUS_OVERFLOW;
		end else begin
			fin_status = s7seg_pkg::STATUS_SHOWN;
		end
		for (int k = 0; k < ROWN; k++) begin
			fin_row[k] = s7seg_pkg::SEG_BLANK;
		end
		for (int k = 0; k < DIGITS; k++) begin
			if (bad_q) begin
				fin_row[k] = s7seg_pkg::SEG_BLANK;
			end else if (overflow) begin
				fin_row[k] = neg_q ? s7seg_pkg::SEG_UNDER : s7seg_pkg::SEG_OVER;
			end else begin
				fin_row[k] = row_q[k];
				if (neg_q && lead_free_q && (k == 0)) begin
					fin_row[k] = s7seg_pkg::SEG_HYPHEN;
				end
				if (neg_q && !lead_free_q && (k == DIGITS - 1)) begin
					fin_row[k] = row_q[k] | s7seg_pkg::SEG_DOT;
				end
			end
		end
	end

	// Output register: hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			out_status_q <= fin_status;
			for (int k = 0; k < s7seg_pkg::OUT_DIGITS; k++) begin
				out_seg_q[k] <= fin_row[k];
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.digit0_segments = out_seg_q[0];
	assign result.digit1_segments = out_seg_q[1];
	assign result.digit2_segments = out_seg_q[2];
	assign result.digit3_segments = out_seg_q[3];
	assign result.status          = out_status_q;

endmodule
